// ----- rtl/olfh_pkg.sv -----
package olfh_pkg;

  // field widths
  localparam int TID_W = 6;
  localparam int ST_W  = 3;
  localparam int WC_W  = 5;

  // thread id space and default waiter queue depth
  localparam int THREAD_COUNT    = 64;
  localparam int QUEUE_DEPTH_DEF = 16;

  // request kinds
  localparam logic REQ_ACQUIRE = 1'b0;
  localparam logic REQ_RELEASE = 1'b1;

  // response status codes
  localparam logic [ST_W-1:0] ST_GRANTED   = 3'd0;
  localparam logic [ST_W-1:0] ST_ALREADY   = 3'd1;
  localparam logic [ST_W-1:0] ST_QUEUED    = 3'd2;
  localparam logic [ST_W-1:0] ST_FREED     = 3'd3;
  localparam logic [ST_W-1:0] ST_HANDOFF   = 3'd4;
  localparam logic [ST_W-1:0] ST_NOT_OWNER = 3'd5;
  localparam logic [ST_W-1:0] ST_FULL      = 3'd6;

  // one lock request
  typedef struct packed {
    logic             req_type;
    logic [TID_W-1:0] thread_id;
  } olfh_req_t;

  // one lock response
  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [TID_W-1:0] new_owner;
    logic             lock_held;
    logic [WC_W-1:0]  waiter_count;
  } olfh_rsp_t;

  // fold a thread id into the supported thread range
  function automatic logic [TID_W-1:0] tid_wrap(input logic [TID_W-1:0] t);
    logic [TID_W-1:0] r;
    r = TID_W'(t % THREAD_COUNT);
    return r;
  endfunction

endpackage

// ----- rtl/olfh_wait_mem.sv -----
module olfh_wait_mem #(
  parameter int DEPTH  = olfh_pkg::QUEUE_DEPTH_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [ADDR_W-1:0]          wr_addr,
  input  logic [olfh_pkg::TID_W-1:0] wr_data,
  input  logic                       rd_en,
  input  logic [ADDR_W-1:0]          rd_addr,
  output logic [olfh_pkg::TID_W-1:0] rd_data
);

  logic [olfh_pkg::TID_W-1:0] mem [DEPTH];
  logic [olfh_pkg::TID_W-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/owned_lock_fifo_handoff_unit.sv -----
// channel  | ports                  | handshake
// ---------+------------------------+------------------------------------------
// request  | start, busy, in_req    | taken on a clock edge with start && !busy
// response | out_valid, out_rsp     | shown for one cycle, receiver cannot stall
//
// each request has a read step, which reads the oldest waiter from the queue
// memory (registered read port), and a decide step, which decides and updates
// the lock state. the response appears the cycle after the decide step; a new
// request can be taken then. busy is high during the decide cycle only.
// reset (rst_n low, synchronous) frees the lock and empties the waiter queue;
// queue memory contents are not cleared, as entries are read only once written.
module owned_lock_fifo_handoff_unit #(
  parameter int QUEUE_DEPTH = olfh_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  olfh_pkg::olfh_req_t in_req,
  output logic                out_valid,
  output olfh_pkg::olfh_rsp_t out_rsp
);

  localparam int ADDR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int TID_W  = olfh_pkg::TID_W;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic                 state_r, state_nxt;
  olfh_pkg::olfh_req_t  req_r;
  logic                 lock_free_r, lock_free_nxt;
  logic [TID_W-1:0]     owner_r, owner_nxt;
  logic [ADDR_W-1:0]    head_r, head_nxt;
  logic [ADDR_W-1:0]    tail_r, tail_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic                 out_valid_r;
  olfh_pkg::olfh_rsp_t  out_rsp_r, rsp_nxt;

  logic                 accept;
  logic                 mem_wr_en;
  logic [TID_W-1:0]     mem_rd_data;
  logic [TID_W-1:0]     tid;
  logic                 held_by_me;
  logic                 queue_full;

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r == S_EXEC);

  // waiter queue storage
  olfh_wait_mem #(
    .DEPTH  (QUEUE_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_wait_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (tail_r),
    .wr_data (tid),
    .rd_en   (accept),
    .rd_addr (head_r),
    .rd_data (mem_rd_data)
  );

  // request decode
  assign tid        = olfh_pkg::tid_wrap(req_r.thread_id);
  assign held_by_me = !lock_free_r && (owner_r == tid);
  assign queue_full = (count_r == CNT_W'(QUEUE_DEPTH));

  // lock and queue update
  always_comb begin
    state_nxt     = state_r;
    lock_free_nxt = lock_free_r;
    owner_nxt     = owner_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    count_nxt     = count_r;
    mem_wr_en     = 1'b0;
    rsp_nxt       = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
        if (req_r.req_type == olfh_pkg::REQ_ACQUIRE) begin
          if (held_by_me) begin
            rsp_nxt.status = olfh_pkg::ST_ALREADY;
          end else if (lock_free_r) begin
            lock_free_nxt  = 1'b0;
            owner_nxt      = tid;
            rsp_nxt.status = olfh_pkg::ST_GRANTED;
          end else if (queue_full) begin
            rsp_nxt.status = olfh_pkg::ST_FULL;
          end else begin
            mem_wr_en      = 1'b1;
            tail_nxt       = (tail_r == ADDR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_r + 1'b1;
            count_nxt      = count_r + 1'b1;
            rsp_nxt.status = olfh_pkg::ST_QUEUED;
          end
        end else begin
          if (!held_by_me) begin
            rsp_nxt.status = olfh_pkg::ST_NOT_OWNER;
          end else if (count_r != '0) begin
            head_nxt          = (head_r == ADDR_W'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
            count_nxt         = count_r - 1'b1;
            owner_nxt         = mem_rd_data;
            rsp_nxt.new_owner = mem_rd_data;
            rsp_nxt.status    = olfh_pkg::ST_HANDOFF;
          end else begin
            lock_free_nxt  = 1'b1;
            owner_nxt      = '0;
            rsp_nxt.status = olfh_pkg::ST_FREED;
          end
        end
        rsp_nxt.lock_held    = !lock_free_nxt;
        rsp_nxt.waiter_count = olfh_pkg::WC_W'(count_nxt);
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      lock_free_r <= 1'b1;
      owner_r     <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      lock_free_r <= lock_free_nxt;
      owner_r     <= owner_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      out_valid_r <= (state_r == S_EXEC);
    end
  end

  // request capture and response payload
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_req;
    end
    if (state_r == S_EXEC) begin
      out_rsp_r <= rsp_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  // an accepted request is worked on in the next cycle
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted request did not enter decide cycle");

  // every decide cycle yields exactly one response
  a_exec_resp: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> (out_valid && !busy))
    else $error("decide cycle produced no response");

  // queue never holds more than its depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r <= CNT_W'(QUEUE_DEPTH)))
    else $error("waiter count above queue depth");

  // a free lock leaves no one waiting
  a_free_empty: assert property (@(posedge clk) disable iff (!rst_n)
    lock_free_r |-> (count_r == '0))
    else $error("waiters queued on a free lock");

  // a handoff keeps the lock held
  a_handoff_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_rsp.status == olfh_pkg::ST_HANDOFF)) |-> out_rsp.lock_held)
    else $error("handoff reported a free lock");

endmodule
